FILE: src/salb_pkg.sv
package salb_pkg;

   localparam int DEF_MAX_LEN  = 4096;
   localparam int DEF_ALPHABET = 128;

   localparam int SYM_W   = 7;
   localparam int FIELD_W = 13;
   localparam int KIND_W  = 2;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_READ = 1'b1;

   localparam logic [KIND_W-1:0] KIND_BUILT = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DATA  = 2'd1;
   localparam logic [KIND_W-1:0] KIND_ERROR = 2'd2;

   typedef struct packed {
      logic start;
      logic txt_we;
   } salb_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } salb_sts_type;

endpackage

FILE: src/salb_engine.sv
module salb_engine
   import salb_pkg::*;
#(
   parameter int MAX_LEN  = DEF_MAX_LEN,
   parameter int ALPHABET = DEF_ALPHABET,
   localparam int DEPTH = MAX_LEN + 1,
   localparam int AW    = $clog2(DEPTH),
   localparam int VW    = $clog2(MAX_LEN + 2)
) (
   input  logic              clock,
   input  logic              reset,
   input  salb_ctl_type      ctl,
   input  logic [AW-1:0]     txt_addr,
   input  logic [SYM_W-1:0]  txt_data,
   input  logic [VW-1:0]     total,
   input  logic [AW-1:0]     rd_addr,
   output logic [VW-1:0]     sa_rdata,
   output logic [VW-1:0]     lcp_rdata,
   output salb_sts_type      sts
);

   localparam int BKD = (ALPHABET > DEPTH) ? ALPHABET : DEPTH;
   localparam int BW  = $clog2(BKD);
   localparam int CW  = (VW > SYM_W) ? VW : SYM_W;
   localparam int NW  = ((VW > BW) ? VW : BW) + 2;

   typedef enum logic [5:0] {
      S_IDLE, S_SENT, S_INIT_RD, S_INIT_WX, S_INIT_WY, S_CLR,
      S_CNT_RY, S_CNT_RX, S_CNT_RB, S_CNT_WB,
      S_PS_R0, S_PS_A0, S_PS_RD, S_PS_WR,
      S_D_RY, S_D_RX, S_D_RB, S_D_WB,
      S_Y1, S_Y2_RD, S_Y2_W,
      S_R0, S_R0W, S_RC_SA, S_RC_B, S_RC_YA, S_RC_YB, S_RC_YAJ, S_RC_YBJ, S_CHECK,
      S_RK_RD, S_RK_W, S_K0, S_K_RR, S_K_R, S_K_P, S_K_CMP, S_K_T1, S_K_T2, S_DONE
   } state_type;

   state_type st_ff;
   logic [NW-1:0] i_ff, p_ff, j_ff, m_ff, k_ff, t_ff;
   logic [NW-1:0] a_ff, b_ff, r_ff, prev_ff;
   logic [CW-1:0] yv_ff, ya_ff;
   logic [VW-1:0] acc_ff;
   logic [SYM_W-1:0] t1_ff;
   logic xs_ff, first_ff;

   logic [SYM_W-1:0] txt_mem [DEPTH];
   logic [VW-1:0]    sa_mem  [DEPTH];
   logic [VW-1:0]    lcp_mem [DEPTH];
   logic [CW-1:0]    cls_mem [2**(AW+1)];
   logic [VW-1:0]    bkt_mem [BKD];

   logic [SYM_W-1:0] txt_q_ff;
   logic [VW-1:0]    sa_q_ff, lcp_q_ff, bkt_q_ff;
   logic [CW-1:0]    cls_q_ff;

   logic             txt_we, sa_we, lcp_we, cls_we, bkt_we;
   logic [AW-1:0]    txt_wa, txt_ra, sa_wa, sa_ra, lcp_wa, lcp_ra;
   logic [AW:0]      cls_wa, cls_ra;
   logic [BW-1:0]    bkt_wa, bkt_ra;
   logic [SYM_W-1:0] txt_wd;
   logic [VW-1:0]    sa_wd, lcp_wd, bkt_wd;
   logic [CW-1:0]    cls_wd;

   logic [NW-1:0] aj, bj, ik, pk, cls_n, sa_n;
   logic          eq0, ne_last, sa_ge_j;

   assign aj      = a_ff + j_ff;
   assign bj      = b_ff + j_ff;
   assign ik      = i_ff + k_ff;
   assign pk      = prev_ff + k_ff;
   assign cls_n   = NW'(cls_q_ff);
   assign sa_n    = NW'(sa_q_ff);
   assign eq0     = (ya_ff == cls_q_ff) && (aj < t_ff) && (bj < t_ff);
   assign ne_last = (ya_ff != cls_q_ff);
   assign sa_ge_j = (sa_n >= j_ff);

   always_comb begin
      txt_we = ctl.txt_we && (st_ff == S_IDLE);
      txt_wa = txt_addr;
      txt_wd = txt_data;
      txt_ra = '0;
      sa_we  = 1'b0;
      sa_wa  = '0;
      sa_wd  = '0;
      sa_ra  = rd_addr;
      lcp_we = 1'b0;
      lcp_wa = '0;
      lcp_wd = '0;
      lcp_ra = rd_addr;
      cls_we = 1'b0;
      cls_wa = '0;
      cls_wd = '0;
      cls_ra = '0;
      bkt_we = 1'b0;
      bkt_wa = '0;
      bkt_wd = '0;
      bkt_ra = '0;
      case (st_ff)
         S_SENT: begin
            txt_we = 1'b1;
            txt_wa = AW'(t_ff - 1'b1);
            txt_wd = '0;
         end
         S_INIT_RD: txt_ra = AW'(i_ff);
         S_INIT_WX: begin
            cls_we = 1'b1;
            cls_wa = {xs_ff, AW'(i_ff)};
            cls_wd = CW'(txt_q_ff);
         end
         S_INIT_WY: begin
            cls_we = 1'b1;
            cls_wa = {~xs_ff, AW'(i_ff)};
            cls_wd = CW'(i_ff);
         end
         S_CLR: begin
            bkt_we = 1'b1;
            bkt_wa = BW'(i_ff);
         end
         S_CNT_RY, S_D_RY: cls_ra = {~xs_ff, AW'(i_ff)};
         S_CNT_RX, S_D_RX: cls_ra = {xs_ff, AW'(cls_q_ff)};
         S_CNT_RB, S_D_RB: bkt_ra = BW'(cls_q_ff);
         S_CNT_WB: begin
            bkt_we = 1'b1;
            bkt_wa = BW'(r_ff);
            bkt_wd = bkt_q_ff + 1'b1;
         end
         S_PS_R0: bkt_ra = '0;
         S_PS_RD: bkt_ra = BW'(i_ff);
         S_PS_WR: begin
            bkt_we = 1'b1;
            bkt_wa = BW'(i_ff);
            bkt_wd = acc_ff + bkt_q_ff;
         end
         S_D_WB: begin
            bkt_we = 1'b1;
            bkt_wa = BW'(r_ff);
            bkt_wd = bkt_q_ff - 1'b1;
            sa_we  = 1'b1;
            sa_wa  = AW'(bkt_q_ff - 1'b1);
            sa_wd  = VW'(yv_ff);
         end
         S_Y1: begin
            cls_we = 1'b1;
            cls_wa = {~xs_ff, AW'(p_ff)};
            cls_wd = CW'(i_ff);
         end
         S_Y2_RD, S_RC_SA, S_RK_RD: sa_ra = AW'(i_ff);
         S_Y2_W: begin
            cls_we = sa_ge_j;
            cls_wa = {~xs_ff, AW'(p_ff)};
            cls_wd = CW'(sa_n - j_ff);
         end
         S_R0: sa_ra = '0;
         S_R0W: begin
            cls_we = 1'b1;
            cls_wa = {xs_ff, AW'(sa_q_ff)};
            cls_wd = '0;
         end
         S_RC_B:  cls_ra = {~xs_ff, AW'(a_ff)};
         S_RC_YA: cls_ra = {~xs_ff, AW'(b_ff)};
         S_RC_YB: begin
            cls_ra = {~xs_ff, AW'(aj)};
            cls_we = !eq0;
            cls_wa = {xs_ff, AW'(b_ff)};
            cls_wd = CW'(p_ff);
         end
         S_RC_YAJ: cls_ra = {~xs_ff, AW'(bj)};
         S_RC_YBJ: begin
            cls_we = 1'b1;
            cls_wa = {xs_ff, AW'(b_ff)};
            cls_wd = ne_last ? CW'(p_ff) : CW'(p_ff - 1'b1);
         end
         S_RK_W: begin
            cls_we = 1'b1;
            cls_wa = {~xs_ff, AW'(sa_q_ff)};
            cls_wd = CW'(i_ff);
         end
         S_K0: begin
            lcp_we = 1'b1;
            lcp_wa = '0;
            lcp_wd = '0;
         end
         S_K_RR: cls_ra = {~xs_ff, AW'(i_ff)};
         S_K_R:  sa_ra = AW'(cls_n - 1'b1);
         S_K_CMP: begin
            txt_ra = AW'(ik);
            lcp_we = !((ik < t_ff) && (pk < t_ff));
            lcp_wa = AW'(r_ff);
            lcp_wd = VW'(k_ff);
         end
         S_K_T1: txt_ra = AW'(pk);
         S_K_T2: begin
            lcp_we = (t1_ff != txt_q_ff);
            lcp_wa = AW'(r_ff);
            lcp_wd = VW'(k_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (txt_we) txt_mem[txt_wa] <= txt_wd;
      if (sa_we)  sa_mem[sa_wa]   <= sa_wd;
      if (lcp_we) lcp_mem[lcp_wa] <= lcp_wd;
      if (cls_we) cls_mem[cls_wa] <= cls_wd;
      if (bkt_we) bkt_mem[bkt_wa] <= bkt_wd;
      txt_q_ff <= txt_mem[txt_ra];
      sa_q_ff  <= sa_mem[sa_ra];
      lcp_q_ff <= lcp_mem[lcp_ra];
      cls_q_ff <= cls_mem[cls_ra];
      bkt_q_ff <= bkt_mem[bkt_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_IDLE;
      end else begin
         case (st_ff)
            S_IDLE: begin
               if (ctl.start) begin
                  t_ff  <= NW'(total);
                  st_ff <= S_SENT;
               end
            end
            S_SENT: begin
               i_ff     <= '0;
               xs_ff    <= 1'b0;
               first_ff <= 1'b1;
               m_ff     <= NW'(ALPHABET);
               st_ff    <= S_INIT_RD;
            end
            S_INIT_RD: st_ff <= S_INIT_WX;
            S_INIT_WX: st_ff <= S_INIT_WY;
            S_INIT_WY: begin
               if (i_ff == t_ff - 1'b1) begin
                  i_ff  <= '0;
                  st_ff <= S_CLR;
               end else begin
                  i_ff  <= i_ff + 1'b1;
                  st_ff <= S_INIT_RD;
               end
            end
            S_CLR: begin
               if (i_ff == m_ff - 1'b1) begin
                  i_ff  <= '0;
                  st_ff <= S_CNT_RY;
               end else begin
                  i_ff <= i_ff + 1'b1;
               end
            end
            S_CNT_RY: st_ff <= S_CNT_RX;
            S_CNT_RX: st_ff <= S_CNT_RB;
            S_CNT_RB: begin
               r_ff  <= cls_n;
               st_ff <= S_CNT_WB;
            end
            S_CNT_WB: begin
               if (i_ff == t_ff - 1'b1) begin
                  st_ff <= S_PS_R0;
               end else begin
                  i_ff  <= i_ff + 1'b1;
                  st_ff <= S_CNT_RY;
               end
            end
            S_PS_R0: st_ff <= S_PS_A0;
            S_PS_A0: begin
               acc_ff <= bkt_q_ff;
               if (m_ff > NW'(1)) begin
                  i_ff  <= NW'(1);
                  st_ff <= S_PS_RD;
               end else begin
                  i_ff  <= t_ff - 1'b1;
                  st_ff <= S_D_RY;
               end
            end
            S_PS_RD: st_ff <= S_PS_WR;
            S_PS_WR: begin
               acc_ff <= acc_ff + bkt_q_ff;
               if (i_ff == m_ff - 1'b1) begin
                  i_ff  <= t_ff - 1'b1;
                  st_ff <= S_D_RY;
               end else begin
                  i_ff  <= i_ff + 1'b1;
                  st_ff <= S_PS_RD;
               end
            end
            S_D_RY: st_ff <= S_D_RX;
            S_D_RX: begin
               yv_ff <= cls_q_ff;
               st_ff <= S_D_RB;
            end
            S_D_RB: begin
               r_ff  <= cls_n;
               st_ff <= S_D_WB;
            end
            S_D_WB: begin
               if (i_ff != '0) begin
                  i_ff  <= i_ff - 1'b1;
                  st_ff <= S_D_RY;
               end else if (first_ff) begin
                  first_ff <= 1'b0;
                  j_ff     <= NW'(1);
                  p_ff     <= '0;
                  i_ff     <= t_ff - 1'b1;
                  st_ff    <= S_Y1;
               end else begin
                  xs_ff <= ~xs_ff;
                  st_ff <= S_R0;
               end
            end
            S_Y1: begin
               p_ff <= p_ff + 1'b1;
               if (i_ff == t_ff - 1'b1) begin
                  i_ff  <= '0;
                  st_ff <= S_Y2_RD;
               end else begin
                  i_ff <= i_ff + 1'b1;
               end
            end
            S_Y2_RD: st_ff <= S_Y2_W;
            S_Y2_W: begin
               if (sa_ge_j) p_ff <= p_ff + 1'b1;
               if (i_ff == t_ff - 1'b1) begin
                  i_ff  <= '0;
                  st_ff <= S_CLR;
               end else begin
                  i_ff  <= i_ff + 1'b1;
                  st_ff <= S_Y2_RD;
               end
            end
            S_R0: st_ff <= S_R0W;
            S_R0W: begin
               a_ff  <= sa_n;
               p_ff  <= NW'(1);
               i_ff  <= NW'(1);
               st_ff <= S_RC_SA;
            end
            S_RC_SA: st_ff <= S_RC_B;
            S_RC_B: begin
               b_ff  <= sa_n;
               st_ff <= S_RC_YA;
            end
            S_RC_YA: begin
               ya_ff <= cls_q_ff;
               st_ff <= S_RC_YB;
            end
            S_RC_YB: begin
               if (eq0) begin
                  st_ff <= S_RC_YAJ;
               end else begin
                  p_ff <= p_ff + 1'b1;
                  a_ff <= b_ff;
                  if (i_ff == t_ff - 1'b1) begin
                     st_ff <= S_CHECK;
                  end else begin
                     i_ff  <= i_ff + 1'b1;
                     st_ff <= S_RC_SA;
                  end
               end
            end
            S_RC_YAJ: begin
               ya_ff <= cls_q_ff;
               st_ff <= S_RC_YBJ;
            end
            S_RC_YBJ: begin
               if (ne_last) p_ff <= p_ff + 1'b1;
               a_ff <= b_ff;
               if (i_ff == t_ff - 1'b1) begin
                  st_ff <= S_CHECK;
               end else begin
                  i_ff  <= i_ff + 1'b1;
                  st_ff <= S_RC_SA;
               end
            end
            S_CHECK: begin
               if ((p_ff >= t_ff) || ({j_ff[NW-2:0], 1'b0} > t_ff)) begin
                  i_ff  <= '0;
                  st_ff <= S_RK_RD;
               end else begin
                  m_ff  <= p_ff;
                  j_ff  <= {j_ff[NW-2:0], 1'b0};
                  p_ff  <= '0;
                  i_ff  <= t_ff - {j_ff[NW-2:0], 1'b0};
                  st_ff <= S_Y1;
               end
            end
            S_RK_RD: st_ff <= S_RK_W;
            S_RK_W: begin
               if (i_ff == t_ff - 1'b1) begin
                  st_ff <= S_K0;
               end else begin
                  i_ff  <= i_ff + 1'b1;
                  st_ff <= S_RK_RD;
               end
            end
            S_K0: begin
               k_ff  <= '0;
               i_ff  <= '0;
               st_ff <= S_K_RR;
            end
            S_K_RR: begin
               if (k_ff != '0) k_ff <= k_ff - 1'b1;
               st_ff <= S_K_R;
            end
            S_K_R: begin
               r_ff <= cls_n;
               if (cls_n == '0) begin
                  if (i_ff + 2'd2 == t_ff) begin
                     st_ff <= S_DONE;
                  end else begin
                     i_ff  <= i_ff + 1'b1;
                     st_ff <= S_K_RR;
                  end
               end else begin
                  st_ff <= S_K_P;
               end
            end
            S_K_P: begin
               prev_ff <= sa_n;
               st_ff   <= S_K_CMP;
            end
            S_K_CMP: begin
               if ((ik < t_ff) && (pk < t_ff)) begin
                  st_ff <= S_K_T1;
               end else if (i_ff + 2'd2 == t_ff) begin
                  st_ff <= S_DONE;
               end else begin
                  i_ff  <= i_ff + 1'b1;
                  st_ff <= S_K_RR;
               end
            end
            S_K_T1: begin
               t1_ff <= txt_q_ff;
               st_ff <= S_K_T2;
            end
            S_K_T2: begin
               if (t1_ff == txt_q_ff) begin
                  k_ff  <= k_ff + 1'b1;
                  st_ff <= S_K_CMP;
               end else if (i_ff + 2'd2 == t_ff) begin
                  st_ff <= S_DONE;
               end else begin
                  i_ff  <= i_ff + 1'b1;
                  st_ff <= S_K_RR;
               end
            end
            S_DONE: st_ff <= S_IDLE;
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   assign sa_rdata  = sa_q_ff;
   assign lcp_rdata = lcp_q_ff;
   assign sts.busy  = (st_ff != S_IDLE);
   assign sts.done  = (st_ff == S_DONE);

endmodule

FILE: src/suffix_array_lcp_builder.sv
// channel | dir | tdata (low bit up)                            | tuser | tlast
// req     | in  | symbol[6:0], rank_index[19:7], zero pad        | cmd   | last_symbol
// rsp     | out | suffix_start[12:0], common_prefix[25:13],      | kind  | -
//         |     | text_length[38:26], zero pad                   |       |
// An error result is registered from the request that caused it; a read request first passes
// through the read state. The final symbol starts a build that holds off requests through the
// first sort, the doubling rounds, the rank pass and the LCP walk.
// Reset clears the control state only; the memories are written before they are read.
// A waiting response does not block a request while rsp_tready is high.
module suffix_array_lcp_builder
   import salb_pkg::*;
#(
   parameter int MAX_LEN  = DEF_MAX_LEN,
   parameter int ALPHABET = DEF_ALPHABET
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // symbol, rank_index
   input  logic        req_tuser,   // cmd
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // suffix_start, common_prefix, text_length
   output logic [1:0]  rsp_tuser    // kind
);

   localparam int DEPTH = MAX_LEN + 1;
   localparam int AW    = $clog2(DEPTH);
   localparam int VW    = $clog2(MAX_LEN + 2);
   localparam int XW    = ((VW > FIELD_W) ? VW : FIELD_W) + 1;

   typedef enum logic [1:0] {T_IDLE, T_READ, T_BUILD} state_type;

   state_type          st_ff;
   logic [VW-1:0]      cnt_ff;
   logic               built_ff;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;
   logic [KIND_W-1:0]  kind_ff;
   logic [FIELD_W-1:0] start_ff, lcp_ff, len_ff;

   logic [SYM_W-1:0]   sym;
   logic [FIELD_W-1:0] rank;
   logic               take, sym_bad, over, rank_bad;
   logic [VW-1:0]      cnt_eff;
   salb_ctl_type       ctl;
   salb_sts_type       sts;
   logic [VW-1:0]      sa_rdata, lcp_rdata;

   assign sym      = req_tdata[SYM_W-1:0];
   assign rank     = req_tdata[SYM_W+FIELD_W-1:SYM_W];
   assign req_tready = (st_ff == T_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign take     = req_tvalid && req_tready;
   assign sym_bad  = (sym == '0) || (9'(sym) >= 9'(ALPHABET));
   assign cnt_eff  = built_ff ? '0 : cnt_ff;
   assign over     = (XW'(cnt_eff) >= XW'(MAX_LEN));
   assign rank_bad = !built_ff || (XW'(rank) > XW'(cnt_ff));

   assign ctl.txt_we = take && (req_tuser == CMD_LOAD) && !sym_bad && !over;
   assign ctl.start  = ctl.txt_we && req_tlast;

   salb_engine #(
      .MAX_LEN  (MAX_LEN),
      .ALPHABET (ALPHABET)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .txt_addr  (AW'(cnt_eff)),
      .txt_data  (sym),
      .total     (cnt_eff + 2'd2),
      .rd_addr   (AW'(rank)),
      .sa_rdata  (sa_rdata),
      .lcp_rdata (lcp_rdata),
      .sts       (sts)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (st_ff)
         T_IDLE: begin
            if (take && ((req_tuser == CMD_LOAD) ? (sym_bad || over) : rank_bad))
               rsp_valid_in = 1'b1;
         end
         T_READ: rsp_valid_in = 1'b1;
         T_BUILD: begin
            if (sts.done) rsp_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= T_IDLE;
         cnt_ff       <= '0;
         built_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         case (st_ff)
            T_IDLE: begin
               if (take) begin
                  start_ff <= '0;
                  lcp_ff   <= '0;
                  kind_ff  <= KIND_ERROR;
                  len_ff   <= ((req_tuser == CMD_LOAD) && !sym_bad && over) ? '0 :
                              FIELD_W'(cnt_ff);
                  if (req_tuser == CMD_LOAD) begin
                     if (sym_bad) begin
                     end else if (over) begin
                        cnt_ff   <= '0;
                        built_ff <= 1'b0;
                     end else begin
                        cnt_ff   <= cnt_eff + 1'b1;
                        built_ff <= 1'b0;
                        if (req_tlast) st_ff <= T_BUILD;
                     end
                  end else if (!rank_bad) begin
                     st_ff <= T_READ;
                  end
               end
            end
            T_READ: begin
               kind_ff  <= KIND_DATA;
               start_ff <= FIELD_W'(sa_rdata);
               lcp_ff   <= FIELD_W'(lcp_rdata);
               st_ff    <= T_IDLE;
            end
            T_BUILD: begin
               if (sts.done) begin
                  kind_ff  <= KIND_BUILT;
                  len_ff   <= FIELD_W'(cnt_ff);
                  built_ff <= 1'b1;
                  st_ff    <= T_IDLE;
               end
            end
            default: st_ff <= T_IDLE;
         endcase
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = kind_ff;
   assign rsp_tdata  = {1'b0, len_ff, lcp_ff, start_ff};

   a_busy_not_built: assert property (@(posedge clock) disable iff (reset)
      sts.busy |-> !built_ff) else $error("built flag set during build");

   a_busy_no_ready: assert property (@(posedge clock) disable iff (reset)
      sts.busy |-> !req_tready) else $error("request taken during build");

   a_done_in_build: assert property (@(posedge clock) disable iff (reset)
      sts.done |-> (st_ff == T_BUILD)) else $error("build done outside build");

   a_read_result: assert property (@(posedge clock) disable iff (reset)
      (st_ff == T_READ) |=> (rsp_tvalid && rsp_tuser == KIND_DATA))
      else $error("read result missing");

endmodule
